// File: src/psm_pkg.sv
// Package for the proximity stop monitor: shared constants, codes and types.
// Depends on nothing; every other file of the block imports it.
package psm_pkg;

    localparam int DEF_COORD_BITS = 20;
    localparam int DEF_TIME_BITS  = 32;
    localparam int NOW_BITS       = 32;
    localparam int HYST_BITS      = 19;
    localparam int CLEAR_BITS     = 20;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 5;
    localparam int QUEUE_DEPTH    = 4;

    localparam int RST_FRONT_MM  = 4000;
    localparam int RST_REAR_MM   = -1000;
    localparam int RST_LEFT_MM   = 1000;
    localparam int RST_RIGHT_MM  = -1000;
    localparam int RST_HYST_MM   = 300;
    localparam int RST_CLEAR_MS  = 2000;

    typedef enum logic {
        KIND_POINT = 1'b0,
        KIND_EVAL  = 1'b1
    } kind_t;

    typedef enum logic {
        MODE_PASS = 1'b0,
        MODE_STOP = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NONE     = 2'd0,
        CMD_SET_ZERO = 2'd1,
        CMD_CLEAR    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_FRONT  = 3'd0,
        REG_REAR   = 3'd1,
        REG_LEFT   = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_HYST   = 3'd4,
        REG_CLEAR  = 3'd5,
        REG_ENABLE = 3'd6
    } reg_idx_t;

    // Settings that do not scale with the coordinate width.
    typedef struct packed {
        logic [HYST_BITS-1:0]  hysteresis_mm;
        logic [CLEAR_BITS-1:0] clear_time_ms;
        logic                  cloud_enable;
    } psm_ctl_t;

endpackage

// File: src/psm_if.sv
// Valid/ready channel interfaces for point/evaluate items and result items.
// Depends on psm_pkg.
interface psm_sample_if
    import psm_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [COORD_BITS-1:0] x_mm;
    logic signed [COORD_BITS-1:0] y_mm;
    logic                         vehicle_stopped;
    logic [NOW_BITS-1:0]          now_ms;

    modport source (output valid, kind, x_mm, y_mm, vehicle_stopped, now_ms, input ready);
    modport sink (input valid, kind, x_mm, y_mm, vehicle_stopped, now_ms, output ready);
endinterface

interface psm_report_if
    import psm_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic                         stop_state;
    logic [1:0]                   command;
    logic                         obstacle_present;
    logic signed [COORD_BITS-1:0] nearest_x_mm;
    logic signed [COORD_BITS-1:0] nearest_y_mm;
    logic [2*COORD_BITS:0]        nearest_dist_sq;

    modport source (output valid, stop_state, command, obstacle_present, nearest_x_mm,
                    nearest_y_mm, nearest_dist_sq, input ready);
    modport sink (input valid, stop_state, command, obstacle_present, nearest_x_mm,
                  nearest_y_mm, nearest_dist_sq, output ready);
endinterface

// File: src/psm_regs.sv
// Configuration register file behind an APB-style port.
// Depends on psm_pkg.
module psm_regs
    import psm_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_BITS-1:0]     paddr,
    input  logic [CFG_DATA_BITS-1:0]     pwdata,
    output logic [CFG_DATA_BITS-1:0]     prdata,
    output logic                         pready,
    output logic signed [COORD_BITS-1:0] front_mm,
    output logic signed [COORD_BITS-1:0] rear_mm,
    output logic signed [COORD_BITS-1:0] left_mm,
    output logic signed [COORD_BITS-1:0] right_mm,
    output psm_ctl_t                     ctl
);

    localparam int EXT_BITS = CFG_DATA_BITS - COORD_BITS;

    logic signed [COORD_BITS-1:0] front_reg;
    logic signed [COORD_BITS-1:0] rear_reg;
    logic signed [COORD_BITS-1:0] left_reg;
    logic signed [COORD_BITS-1:0] right_reg;
    logic [HYST_BITS-1:0]         hyst_reg;
    logic [CLEAR_BITS-1:0]        clear_reg;
    logic                         enable_reg;
    reg_idx_t                     idx;
    logic                         wr_en;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= COORD_BITS'(RST_FRONT_MM);
            rear_reg   <= COORD_BITS'(RST_REAR_MM);
            left_reg   <= COORD_BITS'(RST_LEFT_MM);
            right_reg  <= COORD_BITS'(RST_RIGHT_MM);
            hyst_reg   <= HYST_BITS'(RST_HYST_MM);
            clear_reg  <= CLEAR_BITS'(RST_CLEAR_MS);
            enable_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FRONT:  front_reg  <= pwdata[COORD_BITS-1:0];
                REG_REAR:   rear_reg   <= pwdata[COORD_BITS-1:0];
                REG_LEFT:   left_reg   <= pwdata[COORD_BITS-1:0];
                REG_RIGHT:  right_reg  <= pwdata[COORD_BITS-1:0];
                REG_HYST:   hyst_reg   <= pwdata[HYST_BITS-1:0];
                REG_CLEAR:  clear_reg  <= pwdata[CLEAR_BITS-1:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FRONT:  prdata = {{EXT_BITS{front_reg[COORD_BITS-1]}}, front_reg};
            REG_REAR:   prdata = {{EXT_BITS{rear_reg[COORD_BITS-1]}}, rear_reg};
            REG_LEFT:   prdata = {{EXT_BITS{left_reg[COORD_BITS-1]}}, left_reg};
            REG_RIGHT:  prdata = {{EXT_BITS{right_reg[COORD_BITS-1]}}, right_reg};
            REG_HYST:   prdata = CFG_DATA_BITS'(hyst_reg);
            REG_CLEAR:  prdata = CFG_DATA_BITS'(clear_reg);
            REG_ENABLE: prdata = CFG_DATA_BITS'(enable_reg);
            default:    prdata = '0;
        endcase
    end

    assign front_mm          = front_reg;
    assign rear_mm           = rear_reg;
    assign left_mm           = left_reg;
    assign right_mm          = right_reg;
    assign ctl.hysteresis_mm = hyst_reg;
    assign ctl.clear_time_ms = clear_reg;
    assign ctl.cloud_enable  = enable_reg;

endmodule

// File: src/psm_front.sv
// Front end: accepts items, drops points while the cloud is disabled, and
// works out the per-axis gaps to the ego rectangle. Depends on psm_pkg, psm_if.
module psm_front
    import psm_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int TIME_BITS  = DEF_TIME_BITS,
    parameter int ENTRY_BITS = 4 * COORD_BITS + 4 + TIME_BITS
) (
    psm_sample_if.sink                   sample,
    input  logic signed [COORD_BITS-1:0] front_mm,
    input  logic signed [COORD_BITS-1:0] rear_mm,
    input  logic signed [COORD_BITS-1:0] left_mm,
    input  logic signed [COORD_BITS-1:0] right_mm,
    input  psm_ctl_t                     ctl,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [ENTRY_BITS-1:0]        q_data
);

    localparam int GAP_BITS = COORD_BITS + 1;

    logic [GAP_BITS-1:0] gap_x;
    logic [GAP_BITS-1:0] gap_y;
    logic signed [GAP_BITS-1:0] x_ext, y_ext, fr_ext, re_ext, le_ext, ri_ext;

    assign x_ext  = {sample.x_mm[COORD_BITS-1], sample.x_mm};
    assign y_ext  = {sample.y_mm[COORD_BITS-1], sample.y_mm};
    assign fr_ext = {front_mm[COORD_BITS-1], front_mm};
    assign re_ext = {rear_mm[COORD_BITS-1], rear_mm};
    assign le_ext = {left_mm[COORD_BITS-1], left_mm};
    assign ri_ext = {right_mm[COORD_BITS-1], right_mm};

    // The upper edge is tested first, so swapped limits still give one gap.
    always_comb
    begin
        if (x_ext > fr_ext)
            gap_x = x_ext - fr_ext;
        else if (x_ext < re_ext)
            gap_x = re_ext - x_ext;
        else
            gap_x = '0;

        if (y_ext > le_ext)
            gap_y = y_ext - le_ext;
        else if (y_ext < ri_ext)
            gap_y = ri_ext - y_ext;
        else
            gap_y = '0;
    end

    assign sample.ready = !q_full;
    assign q_push = sample.valid && !q_full &&
                    ((sample.kind == KIND_EVAL) || ctl.cloud_enable);
    assign q_data = {sample.kind, sample.x_mm, sample.y_mm, gap_x, gap_y,
                     sample.vehicle_stopped, TIME_BITS'(sample.now_ms)};

endmodule

// File: src/psm_queue.sv
// Short FIFO between the front end and the tracker back end.
// Depends on psm_pkg for the default depth.
module psm_queue
    import psm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: src/psm_back.sv
// Back end: squares the gaps, tracks the nearest point, runs the pass/stop
// machine on evaluate items and holds the result register. Depends on psm_pkg, psm_if.
module psm_back
    import psm_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int TIME_BITS  = DEF_TIME_BITS,
    parameter int ENTRY_BITS = 4 * COORD_BITS + 4 + TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psm_ctl_t              ctl,
    input  logic                  q_valid,
    input  logic [ENTRY_BITS-1:0] q_data,
    output logic                  q_pop,
    psm_report_if.source          report
);

    localparam int GAP_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * GAP_BITS;
    localparam int DIST_BITS = SQ_BITS + 1;
    localparam int OUT_BITS  = 2 * COORD_BITS + 1;
    localparam int HSQ_BITS  = 2 * HYST_BITS;
    localparam int EL_BITS   = (TIME_BITS > CLEAR_BITS) ? TIME_BITS : CLEAR_BITS;

    // Queue entry fields.
    logic                         e_kind;
    logic signed [COORD_BITS-1:0] e_x, e_y;
    logic [GAP_BITS-1:0]          e_gx, e_gy;
    logic                         e_stopped;
    logic [TIME_BITS-1:0]         e_now;

    assign {e_kind, e_x, e_y, e_gx, e_gy, e_stopped, e_now} = q_data;

    // Square stage.
    logic                         a_valid_reg;
    logic                         a_kind_reg;
    logic signed [COORD_BITS-1:0] a_x_reg, a_y_reg;
    logic [SQ_BITS-1:0]           a_sqx_reg, a_sqy_reg;
    logic                         a_stopped_reg;
    logic [TIME_BITS-1:0]         a_now_reg;
    logic [SQ_BITS-1:0]           sqx, sqy;

    // Tracker and stop machine.
    mode_t                        mode_reg, mode_next;
    logic [TIME_BITS-1:0]         seen_reg, seen_next;
    logic                         seen_valid_reg, seen_valid_next;
    logic [DIST_BITS-1:0]         best_dist_reg, best_dist_next;
    logic signed [COORD_BITS-1:0] best_x_reg, best_x_next;
    logic signed [COORD_BITS-1:0] best_y_reg, best_y_next;
    logic                         best_valid_reg, best_valid_next;
    logic [HSQ_BITS-1:0]          hyst_sq_reg;

    // Result register.
    logic                         out_valid_reg, out_valid_next;
    mode_t                        out_mode_reg, out_mode_next;
    cmd_t                         out_cmd_reg, out_cmd_next;
    logic                         out_present_reg, out_present_next;
    logic signed [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic signed [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic [OUT_BITS-1:0]          out_dist_reg, out_dist_next;

    logic                 take, a_ready, is_eval;
    logic [DIST_BITS-1:0] pt_dist;
    logic                 found, fresh, required;
    logic [TIME_BITS-1:0] elapsed;
    cmd_t                 cmd;

    assign sqx = e_gx * e_gx;
    assign sqy = e_gy * e_gy;

    assign is_eval = (a_kind_reg == KIND_EVAL);
    // A point never waits; an evaluate item needs a free result register.
    assign take    = a_valid_reg && (!is_eval || !out_valid_reg || report.ready);
    assign a_ready = !a_valid_reg || take;
    assign q_pop   = q_valid && a_ready;

    assign pt_dist = DIST_BITS'(a_sqx_reg) + DIST_BITS'(a_sqy_reg);
    assign elapsed = a_now_reg - seen_reg;
    assign fresh   = seen_valid_reg && (EL_BITS'(elapsed) <= EL_BITS'(ctl.clear_time_ms));

    always_comb
    begin
        if (mode_reg == MODE_PASS)
            found = best_valid_reg && (best_dist_reg == '0);
        else
            found = best_valid_reg && (best_dist_reg < DIST_BITS'(hyst_sq_reg));
    end

    always_comb
    begin
        mode_next        = mode_reg;
        seen_next        = seen_reg;
        seen_valid_next  = seen_valid_reg;
        best_dist_next   = best_dist_reg;
        best_x_next      = best_x_reg;
        best_y_next      = best_y_reg;
        best_valid_next  = best_valid_reg;
        out_valid_next   = out_valid_reg && !report.ready;
        out_mode_next    = out_mode_reg;
        out_cmd_next     = out_cmd_reg;
        out_present_next = out_present_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_dist_next    = out_dist_reg;
        required         = 1'b0;
        cmd              = CMD_NONE;

        if (a_stopped_reg)
        begin
            if (found)
            begin
                required        = 1'b1;
                seen_next       = a_now_reg;
                seen_valid_next = 1'b1;
            end
            else if (mode_reg == MODE_STOP)
            begin
                if (fresh)
                    required = 1'b1;
                else
                    seen_valid_next = 1'b0;
            end
        end

        case (mode_reg)
            MODE_PASS:
            begin
                if (required)
                    cmd = CMD_SET_ZERO;
            end
            MODE_STOP:
            begin
                if (!required)
                    cmd = CMD_CLEAR;
            end
            default: cmd = CMD_NONE;
        endcase

        if (take && is_eval)
        begin
            mode_next        = required ? MODE_STOP : MODE_PASS;
            out_valid_next   = 1'b1;
            out_mode_next    = required ? MODE_STOP : MODE_PASS;
            out_cmd_next     = cmd;
            out_present_next = best_valid_reg;
            out_x_next       = best_valid_reg ? best_x_reg : '0;
            out_y_next       = best_valid_reg ? best_y_reg : '0;
            out_dist_next    = best_valid_reg ? best_dist_reg[OUT_BITS-1:0] : '0;
            best_valid_next  = 1'b0;
        end
        else
        begin
            // The sighting only moves on an evaluate item.
            mode_next       = mode_reg;
            seen_next       = seen_reg;
            seen_valid_next = seen_valid_reg;
            if (take && (!best_valid_reg || pt_dist < best_dist_reg))
            begin
                best_dist_next  = pt_dist;
                best_x_next     = a_x_reg;
                best_y_next     = a_y_reg;
                best_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            mode_reg       <= MODE_PASS;
            seen_reg       <= '0;
            seen_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= q_valid;
            mode_reg       <= mode_next;
            seen_reg       <= seen_next;
            seen_valid_reg <= seen_valid_next;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_kind_reg    <= e_kind;
            a_x_reg       <= e_x;
            a_y_reg       <= e_y;
            a_sqx_reg     <= sqx;
            a_sqy_reg     <= sqy;
            a_stopped_reg <= e_stopped;
            a_now_reg     <= e_now;
        end
        hyst_sq_reg     <= ctl.hysteresis_mm * ctl.hysteresis_mm;
        best_dist_reg   <= best_dist_next;
        best_x_reg      <= best_x_next;
        best_y_reg      <= best_y_next;
        out_mode_reg    <= out_mode_next;
        out_cmd_reg     <= out_cmd_next;
        out_present_reg <= out_present_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_dist_reg    <= out_dist_next;
    end

    assign report.valid            = out_valid_reg;
    assign report.stop_state       = out_mode_reg;
    assign report.command          = out_cmd_reg;
    assign report.obstacle_present = out_present_reg;
    assign report.nearest_x_mm     = out_x_reg;
    assign report.nearest_y_mm     = out_y_reg;
    assign report.nearest_dist_sq  = out_dist_reg;

endmodule

// File: src/proximity_stop_monitor_core.sv
// Top level of the proximity stop monitor: register file, front end, queue, back end.
// Depends on psm_pkg, psm_if, psm_regs, psm_front, psm_queue and psm_back.
//
// The block takes one item per clock cycle, point or evaluate, with no stall
// of its own: a point costs two squares, a compare and a minimum update, done
// in a two-stage back end behind a four-entry queue. An accepted evaluate item
// goes through the queue and the square stage to an output register; while
// its result waits to be taken, points keep flowing in, but a second evaluate
// item waits in the back end until the register frees, and the items behind
// it then fill the queue and stall the input. Points are measured against the
// ego rectangle set by the limit registers. The user writes configuration over
// the APB port only while no item is in flight; the block does not enforce it.
module proximity_stop_monitor_core
    import psm_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    psm_sample_if.sink               sample,
    psm_report_if.source             report,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int ENTRY_BITS = 4 * COORD_BITS + 4 + TIME_BITS;

    logic signed [COORD_BITS-1:0] front_mm, rear_mm, left_mm, right_mm;
    psm_ctl_t                     ctl;
    logic                         q_full, q_push, q_pop, q_valid;
    logic [ENTRY_BITS-1:0]        q_wdata, q_rdata;

    psm_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .front_mm (front_mm),
        .rear_mm  (rear_mm),
        .left_mm  (left_mm),
        .right_mm (right_mm),
        .ctl      (ctl)
    );

    psm_front #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .sample   (sample),
        .front_mm (front_mm),
        .rear_mm  (rear_mm),
        .left_mm  (left_mm),
        .right_mm (right_mm),
        .ctl      (ctl),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    psm_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_rdata)
    );

    psm_back #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .report  (report)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for proximity_stop_monitor_core: directed and random point/evaluate
// traffic, APB register settings, idle and backpressure phases, checked against a local predictor.
// Depends on psm_pkg, psm_if and the RTL of proximity_stop_monitor_core.
module tb;
    import psm_pkg::*;

    localparam int CB = DEF_COORD_BITS;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 4000;
    localparam longint COORD_MAX = (longint'(1) << (CB - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef struct {
        kind_t                kind;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 stopped;
        logic [NOW_BITS-1:0]  now;
    } sample_t;

    typedef struct {
        mode_t                state;
        cmd_t                 cmd;
        logic                 present;
        logic signed [CB-1:0] nx;
        logic signed [CB-1:0] ny;
        logic [2*CB:0]        dist_sq;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic pready;

    psm_sample_if #(.COORD_BITS(CB)) smp ();
    psm_report_if #(.COORD_BITS(CB)) rpt ();

    proximity_stop_monitor_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp),
        .report  (rpt),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor copy of the registers and of the tracker and stop machine.
    logic signed [CB-1:0] lim_front;
    logic signed [CB-1:0] lim_rear;
    logic signed [CB-1:0] lim_left;
    logic signed [CB-1:0] lim_right;
    logic [HYST_BITS-1:0] hyst_mm;
    logic [CLEAR_BITS-1:0] clear_ms;
    logic points_on;
    mode_t stop_mode;
    logic [NOW_BITS-1:0] seen_ms;
    bit seen_valid;
    longint best_dist;
    logic signed [CB-1:0] best_x;
    logic signed [CB-1:0] best_y;
    bit best_valid;

    verdict_t pending_verdicts[$];
    int fail_count = 0;
    int quiet_cycles = 0;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_request;
    int hold_left;
    logic [NOW_BITS-1:0] clock_ms;

    function automatic void reset_model();
        lim_front = CB'(RST_FRONT_MM);
        lim_rear = CB'(RST_REAR_MM);
        lim_left = CB'(RST_LEFT_MM);
        lim_right = CB'(RST_RIGHT_MM);
        hyst_mm = HYST_BITS'(RST_HYST_MM);
        clear_ms = CLEAR_BITS'(RST_CLEAR_MS);
        points_on = 1'b1;
        stop_mode = MODE_PASS;
        seen_ms = '0;
        seen_valid = 1'b0;
        best_dist = 0;
        best_x = '0;
        best_y = '0;
        best_valid = 1'b0;
    endfunction

    function automatic longint axis_gap(longint v, longint lo, longint hi);
        if (v > hi)
            return v - hi;
        if (v < lo)
            return lo - v;
        return 0;
    endfunction

    function automatic void track_item(kind_t kind, logic signed [CB-1:0] x,
                                       logic signed [CB-1:0] y, logic stopped,
                                       logic [NOW_BITS-1:0] now);
        longint dx;
        longint dy;
        longint d;
        logic [NOW_BITS-1:0] elapsed;
        bit found;
        bit need;
        verdict_t v;
        if (kind == KIND_POINT) begin
            if (!points_on)
                return;
            dx = axis_gap(x, lim_rear, lim_front);
            dy = axis_gap(y, lim_right, lim_left);
            d = dx * dx + dy * dy;
            if (!best_valid || d < best_dist) begin
                best_dist = d;
                best_x = x;
                best_y = y;
                best_valid = 1'b1;
            end
            return;
        end
        if (stop_mode == MODE_PASS)
            found = best_valid && best_dist == 0;
        else
            found = best_valid && best_dist < longint'(hyst_mm) * longint'(hyst_mm);
        // A failed hold forgets the sighting; a moving vehicle leaves it alone.
        need = 1'b0;
        if (stopped) begin
            if (found) begin
                seen_ms = now;
                seen_valid = 1'b1;
                need = 1'b1;
            end else if (stop_mode == MODE_STOP) begin
                elapsed = now - seen_ms;
                if (seen_valid && elapsed <= clear_ms)
                    need = 1'b1;
                else
                    seen_valid = 1'b0;
            end
        end
        v.cmd = CMD_NONE;
        if (stop_mode == MODE_PASS && need) begin
            stop_mode = MODE_STOP;
            v.cmd = CMD_SET_ZERO;
        end else if (stop_mode == MODE_STOP && !need) begin
            stop_mode = MODE_PASS;
            v.cmd = CMD_CLEAR;
        end
        v.state = stop_mode;
        v.present = best_valid;
        v.nx = best_valid ? best_x : '0;
        v.ny = best_valid ? best_y : '0;
        v.dist_sq = best_valid ? best_dist[2*CB:0] : '0;
        pending_verdicts.insert(pending_verdicts.size(), v);
        best_valid = 1'b0;
        best_dist = 0;
        best_x = '0;
        best_y = '0;
    endfunction

    function automatic void compare_field(string name, logic signed [63:0] want,
                                          logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_report();
        verdict_t want;
        if (pending_verdicts.size() == 0) begin
            $display("%0t: result item with no evaluate item outstanding", $time);
            fail_count++;
            return;
        end
        want = pending_verdicts.pop_front();
        compare_field("stop_state", want.state, rpt.stop_state);
        compare_field("command", want.cmd, rpt.command);
        compare_field("obstacle_present", want.present, rpt.obstacle_present);
        compare_field("nearest_x_mm", want.nx, rpt.nearest_x_mm);
        compare_field("nearest_y_mm", want.ny, rpt.nearest_y_mm);
        compare_field("nearest_dist_sq", want.dist_sq, rpt.nearest_dist_sq);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rpt.valid && rpt.ready)
                check_report();
            if (smp.valid && smp.ready)
                track_item(kind_t'(smp.kind), smp.x_mm, smp.y_mm, smp.vehicle_stopped,
                           smp.now_ms);
        end
    end

    always @(posedge clk)
    begin
        if ((smp.valid && smp.ready) || (rpt.valid && rpt.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL proximity_stop_monitor_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rpt.ready <= 1'b0;
            end else begin
                rpt.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    function automatic logic signed [CB-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return CB'(v);
    endfunction

    task automatic send_item(sample_t s);
        while ($urandom_range(99) < src_idle_pct) begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid <= 1'b1;
        smp.kind <= s.kind;
        smp.x_mm <= s.x;
        smp.y_mm <= s.y;
        smp.vehicle_stopped <= s.stopped;
        smp.now_ms <= s.now;
        do @(posedge clk); while (!smp.ready);
        @(negedge clk);
    endtask

    task automatic send_point(longint x, longint y);
        sample_t s;
        s.kind = KIND_POINT;
        s.x = clamp_coord(x);
        s.y = clamp_coord(y);
        s.stopped = 1'($urandom_range(1));
        s.now = $urandom();
        send_item(s);
    endtask

    task automatic send_eval(logic stopped, logic [NOW_BITS-1:0] now);
        sample_t s;
        s.kind = KIND_EVAL;
        s.x = CB'($urandom());
        s.y = CB'($urandom());
        s.stopped = stopped;
        s.now = now;
        send_item(s);
    endtask

    // Waits until every result is in and the point pipeline has emptied.
    task automatic drain();
        smp.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(reg_idx_t idx, longint value);
        logic [CFG_DATA_BITS-1:0] data;
        data = CFG_DATA_BITS'(value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_FRONT:  lim_front = data[CB-1:0];
            REG_REAR:   lim_rear = data[CB-1:0];
            REG_LEFT:   lim_left = data[CB-1:0];
            REG_RIGHT:  lim_right = data[CB-1:0];
            REG_HYST:   hyst_mm = data[HYST_BITS-1:0];
            REG_CLEAR:  clear_ms = data[CLEAR_BITS-1:0];
            REG_ENABLE: points_on = data[0];
            default: ;
        endcase
    endtask

    // Inside the span, on an edge, within reach of an edge, or anywhere.
    function automatic longint near_value(longint lo, longint hi, longint reach);
        longint a;
        longint b;
        logic signed [CB-1:0] raw;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        raw = CB'($urandom());
        case ($urandom_range(4))
            0: return a + longint'($urandom_range(32'(b - a)));
            1: return a - reach + longint'($urandom_range(32'(2 * reach)));
            2: return b - reach + longint'($urandom_range(32'(2 * reach)));
            3: return raw;
            default: return $urandom_range(1) ? b : a;
        endcase
    endfunction

    task automatic send_near_point();
        longint reach;
        reach = ((hyst_mm > 3000) ? 3000 : longint'(hyst_mm)) + 20;
        send_point(near_value(lim_rear, lim_front, reach),
                   near_value(lim_right, lim_left, reach));
    endtask

    task automatic send_noise();
        logic signed [CB-1:0] rx;
        logic signed [CB-1:0] ry;
        rx = CB'($urandom());
        ry = CB'($urandom());
        if ($urandom_range(1))
            send_point(rx, ry);
        else
            send_eval(1'($urandom_range(1)), $urandom());
    endtask

    task automatic choose_setting();
        longint f;
        longint r;
        longint l;
        longint rt;
        longint tmp;
        f = longint'($urandom_range(8000)) - 2000;
        r = f - longint'($urandom_range(6000));
        l = longint'($urandom_range(3000)) - 500;
        rt = l - longint'($urandom_range(3000));
        case ($urandom_range(7))
            0: begin
                tmp = f;
                f = r;
                r = tmp;
                tmp = l;
                l = rt;
                rt = tmp;
            end
            1: begin
                f = COORD_MAX;
                r = COORD_MIN;
            end
            default: ;
        endcase
        set_reg(REG_FRONT, f);
        set_reg(REG_REAR, r);
        set_reg(REG_LEFT, l);
        set_reg(REG_RIGHT, rt);
        set_reg(REG_HYST, ($urandom_range(9) == 0) ? 0 : $urandom_range(1000));
        case ($urandom_range(9))
            0: set_reg(REG_CLEAR, 0);
            1: set_reg(REG_CLEAR, (1 << CLEAR_BITS) - 1);
            default: set_reg(REG_CLEAR, $urandom_range(3000));
        endcase
        set_reg(REG_ENABLE, $urandom_range(9) != 0);
    endtask

    task automatic advance_clock();
        if ($urandom_range(19) == 0)
            clock_ms = clock_ms - $urandom_range(100);
        else
            clock_ms = clock_ms + $urandom_range(32'(clear_ms) + 32'(clear_ms) / 2 + 5);
    endtask

    task automatic test_stop_machine();
        send_point(0, 0);
        send_eval(1'b1, 100);
        // Hold ends exactly one millisecond past the clear time.
        send_eval(1'b1, 2100);
        send_eval(1'b1, 2101);
        // Equal distances: the first point must be kept.
        send_point(4100, 0);
        send_point(4000, 1100);
        send_point(COORD_MIN, COORD_MAX);
        send_point(COORD_MAX, COORD_MIN);
        send_eval(1'b1, 3000);
        send_point(4299, 0);
        send_eval(1'b1, 3100);
        send_point(500, -1000);
        send_eval(1'b1, 4000);
        send_point(4299, 0);
        send_eval(1'b1, 9000);
        send_point(4300, 0);
        send_eval(1'b1, 11001);
        // A clock that runs backwards looks like a very old sighting.
        send_point(0, 0);
        send_eval(1'b1, 20000);
        send_eval(1'b1, 19999);
        send_point(0, 0);
        send_eval(1'b1, 32'hFFFF_FFFF);
        send_eval(1'b0, 0);
        send_point(0, 0);
        send_eval(1'b0, 0);
        drain();
    endtask

    task automatic test_register_extremes();
        // Swapped limits.
        set_reg(REG_FRONT, -100);
        set_reg(REG_REAR, 100);
        set_reg(REG_LEFT, -50);
        set_reg(REG_RIGHT, 50);
        send_point(0, 0);
        send_point(-100, 50);
        send_point(100, -50);
        send_eval(1'b1, 100);
        drain();
        // Largest possible distance.
        set_reg(REG_FRONT, COORD_MIN);
        set_reg(REG_REAR, COORD_MIN);
        set_reg(REG_LEFT, COORD_MAX);
        set_reg(REG_RIGHT, COORD_MAX);
        send_point(COORD_MAX, COORD_MIN);
        send_eval(1'b0, 200);
        drain();
        set_reg(REG_FRONT, COORD_MAX);
        set_reg(REG_REAR, COORD_MIN);
        set_reg(REG_LEFT, COORD_MAX);
        set_reg(REG_RIGHT, COORD_MIN);
        set_reg(REG_HYST, (1 << HYST_BITS) - 1);
        set_reg(REG_CLEAR, (1 << CLEAR_BITS) - 1);
        send_point(COORD_MIN, COORD_MAX);
        send_eval(1'b1, 300);
        send_eval(1'b1, 300 + (1 << CLEAR_BITS) - 1);
        send_eval(1'b1, 300 + (1 << CLEAR_BITS));
        drain();
        set_reg(REG_HYST, 0);
        set_reg(REG_CLEAR, 0);
        set_reg(REG_ENABLE, 0);
        send_point(0, 0);
        send_point(COORD_MAX, COORD_MAX);
        send_eval(1'b1, 5000);
        drain();
        set_reg(REG_ENABLE, 1);
        send_point(0, 0);
        send_eval(1'b1, 6000);
        send_point(1, 1);
        send_eval(1'b1, 6000);
        send_eval(1'b1, 6001);
        drain();
    endtask

    task automatic test_random_traffic();
        int phase;
        int seg;
        int sent;
        int k;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin src_idle_pct = 13; sink_stall_pct = 13; end
            endcase
            for (seg = 0; seg < 4; seg++) begin
                drain();
                choose_setting();
                sent = 0;
                while (sent < 125) begin
                    if ($urandom_range(9) == 0) begin
                        send_noise();
                        sent++;
                    end else begin
                        k = $urandom_range(6);
                        repeat (k) send_near_point();
                        advance_clock();
                        send_eval($urandom_range(9) != 0, clock_ms);
                        sent += k + 1;
                    end
                end
            end
        end
        src_idle_pct = 0;
        sink_stall_pct = 0;
        drain();
    endtask

    // A long receiver hold-off: a second evaluate item must stall the input.
    task automatic test_output_backlog();
        int i;
        set_reg(REG_ENABLE, 1);
        hold_request = 400;
        for (i = 0; i < 30; i++) begin
            send_near_point();
            send_near_point();
            clock_ms = clock_ms + 50;
            send_eval(1'b1, clock_ms);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        smp.valid = 1'b0;
        smp.kind = KIND_POINT;
        smp.x_mm = '0;
        smp.y_mm = '0;
        smp.vehicle_stopped = 1'b0;
        smp.now_ms = '0;
        rpt.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        clock_ms = '0;
        reset_model();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_stop_machine();
        test_register_extremes();
        test_random_traffic();
        test_output_backlog();

        drain();
        if (fail_count == 0)
            $display("PASS proximity_stop_monitor_core");
        else
            $display("FAIL proximity_stop_monitor_core");
        $finish;
    end

endmodule
